// ----- rtl/core/plt_pkg.sv -----
// Shared types, codes and sizes for the peer liveness table.
package plt_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int ADDR_W    = 32;
    localparam int TIME_W    = 32;
    localparam int AGE_W     = 16;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REPLY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHECK = 3'd4;

    localparam logic [KIND_W-1:0] RK_ACK  = 3'd0;
    localparam logic [KIND_W-1:0] RK_UP   = 3'd1;
    localparam logic [KIND_W-1:0] RK_DOWN = 3'd2;
    localparam logic [KIND_W-1:0] RK_PING = 3'd3;
    localparam logic [KIND_W-1:0] RK_DONE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKDATE = 2'd2;

    localparam logic [AGE_W-1:0] EXPIRE_RST   = 16'd10;
    localparam logic [AGE_W-1:0] VALID_RST    = 16'd6;
    localparam logic [AGE_W-1:0] BACKDATE_RST = 16'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_DECIDE,
        OP_INSERT,
        OP_DELETE,
        OP_REPLY,
        OP_CHK1,
        OP_CHK2,
        OP_IDX_CLR
    } op_t;

    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_ENTRY,
        SRC_ZERO
    } src_t;

    typedef struct packed {
        op_t               op;
        logic              emit;
        logic [KIND_W-1:0] rkind;
        src_t              src;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              walk_end;
        logic              found;
        logic              add_good;
        logic              p_alive;
        logic              chk1_hit;
        logic              chk2_hit;
        logic              out_free;
    } stat_t;

endpackage

// ----- rtl/core/plt_datapath.sv -----
// Datapath: peer table, input and config registers, check arithmetic, result register.
module plt_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [plt_pkg::KIND_W-1:0]    in_kind,
    input  logic [plt_pkg::ADDR_W-1:0]    in_addr,
    input  logic [plt_pkg::TIME_W-1:0]    in_now,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [plt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plt_pkg::AGE_W-1:0]     cfg_data,
    input  plt_pkg::cmd_t                 cmd,
    output plt_pkg::stat_t                stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [plt_pkg::KIND_W-1:0]    out_kind,
    output logic [plt_pkg::ADDR_W-1:0]    out_addr,
    output logic                          out_up,
    output logic                          out_ok,
    output logic                          out_last
);
    import plt_pkg::*;

    logic [ADDR_W-1:0] entry_addr_reg  [DEPTH];
    logic [ADDR_W-1:0] entry_addr_next [DEPTH];
    logic [TIME_W-1:0] entry_seen_reg  [DEPTH];
    logic [TIME_W-1:0] entry_seen_next [DEPTH];
    logic              entry_alive_reg [DEPTH];
    logic              entry_alive_next[DEPTH];

    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  p_reg, p_next;
    logic              found_reg, found_next;
    logic              p_alive_reg, p_alive_next;
    logic              ok_reg, ok_next;
    logic              up_reg, up_next;

    logic [AGE_W-1:0]  expire_reg, valid_reg, backdate_reg;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic              out_up_reg, out_up_next;
    logic              out_ok_reg, out_ok_next;
    logic              out_last_reg, out_last_next;

    logic [IDX_W-1:0]  cur;
    logic [ADDR_W-1:0] rd_addr;
    logic [TIME_W-1:0] rd_seen;
    logic              rd_alive;
    logic [TIME_W-1:0] seen_clamp;
    logic [TIME_W-1:0] age1;
    logic [TIME_W-1:0] age2;
    logic              chk1_hit;
    logic              chk2_low;
    logic              chk2_old;
    logic              add_good;
    logic              out_free;

    assign cur      = idx_reg[IDX_W-1:0];
    assign rd_addr  = entry_addr_reg[cur];
    assign rd_seen  = entry_seen_reg[cur];
    assign rd_alive = entry_alive_reg[cur];

    assign seen_clamp = (now_reg < rd_seen) ? now_reg : rd_seen;
    assign age1       = now_reg - seen_clamp;
    assign chk1_hit   = rd_alive && (age1 >= TIME_W'(expire_reg));
    assign age2       = now_reg - rd_seen;
    assign chk2_low   = age2 < TIME_W'(valid_reg);
    assign chk2_old   = age2 > TIME_W'(expire_reg);

    assign add_good = !found_reg && (cnt_reg != CNT_W'(DEPTH));
    assign out_free = !out_valid_reg || out_ready;

    assign stat.kind     = kind_reg;
    assign stat.walk_end = (idx_reg == cnt_reg);
    assign stat.found    = found_reg;
    assign stat.add_good = add_good;
    assign stat.p_alive  = p_alive_reg;
    assign stat.chk1_hit = chk1_hit;
    assign stat.chk2_hit = !chk2_low && !chk2_old;
    assign stat.out_free = out_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        now_next     = now_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        p_next       = p_reg;
        found_next   = found_reg;
        p_alive_next = p_alive_reg;
        ok_next      = ok_reg;
        up_next      = up_reg;
        for (int j = 0; j < DEPTH; j++)
        begin
            entry_addr_next[j]  = entry_addr_reg[j];
            entry_seen_next[j]  = entry_seen_reg[j];
            entry_alive_next[j] = entry_alive_reg[j];
        end

        unique case (cmd.op)
            OP_LOAD:
            begin
                kind_next    = in_kind;
                addr_next    = in_addr;
                now_next     = in_now;
                idx_next     = '0;
                pos_next     = '0;
                p_next       = '0;
                found_next   = 1'b0;
                p_alive_next = 1'b0;
            end
            OP_SCAN:
            begin
                if (rd_addr == addr_reg)
                begin
                    found_next   = 1'b1;
                    p_next       = cur;
                    p_alive_next = rd_alive;
                end
                if (rd_addr <= addr_reg)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            OP_DECIDE:
            begin
                case (kind_reg)
                    KIND_ADD:
                    begin
                        idx_next = cnt_reg;
                        ok_next  = add_good;
                    end
                    KIND_DEL, KIND_REPLY, KIND_QUERY:
                    begin
                        idx_next = CNT_W'(p_reg);
                        ok_next  = found_reg;
                    end
                    KIND_CHECK:
                    begin
                        idx_next = '0;
                        ok_next  = 1'b0;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
                up_next = (kind_reg == KIND_QUERY) && found_reg && p_alive_reg;
            end
            OP_INSERT:
            begin
                for (int j = 0; j < DEPTH; j++)
                begin
                    if (CNT_W'(j) == pos_reg)
                    begin
                        entry_addr_next[j]  = addr_reg;
                        entry_seen_next[j]  = now_reg - TIME_W'(backdate_reg);
                        entry_alive_next[j] = 1'b1;
                    end
                    else if (j > 0 && CNT_W'(j) > pos_reg && CNT_W'(j) <= cnt_reg)
                    begin
                        entry_addr_next[j]  = entry_addr_reg[(j > 0) ? j - 1 : 0];
                        entry_seen_next[j]  = entry_seen_reg[(j > 0) ? j - 1 : 0];
                        entry_alive_next[j] = entry_alive_reg[(j > 0) ? j - 1 : 0];
                    end
                end
                cnt_next = cnt_reg + 1'b1;
            end
            OP_DELETE:
            begin
                for (int j = 0; j < DEPTH - 1; j++)
                begin
                    if (CNT_W'(j) >= CNT_W'(p_reg) && CNT_W'(j + 1) < cnt_reg)
                    begin
                        entry_addr_next[j]  = entry_addr_reg[j + 1];
                        entry_seen_next[j]  = entry_seen_reg[j + 1];
                        entry_alive_next[j] = entry_alive_reg[j + 1];
                    end
                end
                cnt_next = cnt_reg - 1'b1;
            end
            OP_REPLY:
            begin
                entry_seen_next[cur]  = now_reg;
                entry_alive_next[cur] = 1'b1;
            end
            OP_CHK1:
            begin
                entry_seen_next[cur] = seen_clamp;
                if (chk1_hit)
                begin
                    entry_alive_next[cur] = 1'b0;
                end
                idx_next = idx_reg + 1'b1;
            end
            OP_CHK2:
            begin
                if (!chk2_low && chk2_old)
                begin
                    entry_seen_next[cur] = now_reg;
                end
                idx_next = idx_reg + 1'b1;
            end
            OP_IDX_CLR:
            begin
                idx_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_up_next    = out_up_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = cmd.rkind;
            out_last_next  = cmd.last;
            out_up_next    = (cmd.rkind == RK_ACK) ? up_reg : 1'b0;
            out_ok_next    = (cmd.rkind == RK_ACK) ? ok_reg : 1'b0;
            unique case (cmd.src)
                SRC_INPUT: out_addr_next = addr_reg;
                SRC_ENTRY: out_addr_next = rd_addr;
                default:   out_addr_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            entry_addr_reg[j]  <= entry_addr_next[j];
            entry_seen_reg[j]  <= entry_seen_next[j];
            entry_alive_reg[j] <= entry_alive_next[j];
        end
        kind_reg     <= kind_next;
        addr_reg     <= addr_next;
        now_reg      <= now_next;
        pos_reg      <= pos_next;
        p_reg        <= p_next;
        found_reg    <= found_next;
        p_alive_reg  <= p_alive_next;
        ok_reg       <= ok_next;
        up_reg       <= up_next;
        out_kind_reg <= out_kind_next;
        out_addr_reg <= out_addr_next;
        out_up_reg   <= out_up_next;
        out_ok_reg   <= out_ok_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            expire_reg    <= EXPIRE_RST;
            valid_reg     <= VALID_RST;
            backdate_reg  <= BACKDATE_RST;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_EXPIRE:   expire_reg   <= cfg_data;
                    CFG_VALID:    valid_reg    <= cfg_data;
                    CFG_BACKDATE: backdate_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_addr  = out_addr_reg;
    assign out_up    = out_up_reg;
    assign out_ok    = out_ok_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- rtl/core/plt_ctrl.sv -----
// Controller: sequences scan, update, check walks and result beats.
module plt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  plt_pkg::stat_t stat,
    output plt_pkg::cmd_t  cmd
);
    import plt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DISPATCH,
        ST_INSERT,
        ST_DELETE,
        ST_REPLY,
        ST_ACK,
        ST_CHK1,
        ST_CHK2,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.emit   = 1'b0;
        cmd.rkind  = RK_ACK;
        cmd.src    = SRC_INPUT;
        cmd.last   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.walk_end)
                begin
                    state_next = ST_DISPATCH;
                end
                else
                begin
                    cmd.op = OP_SCAN;
                end
            end
            ST_DISPATCH:
            begin
                cmd.op = OP_DECIDE;
                unique case (stat.kind)
                    KIND_ADD:   state_next = stat.add_good ? ST_INSERT : ST_ACK;
                    KIND_DEL:   state_next = stat.found ? ST_DELETE : ST_ACK;
                    KIND_REPLY: state_next = stat.found ? ST_REPLY : ST_ACK;
                    KIND_CHECK: state_next = ST_CHK1;
                    default:    state_next = ST_ACK;
                endcase
            end
            ST_INSERT:
            begin
                cmd.op     = OP_INSERT;
                state_next = ST_ACK;
            end
            ST_DELETE:
            begin
                cmd.op     = OP_DELETE;
                state_next = ST_ACK;
            end
            ST_REPLY:
            begin
                if (stat.p_alive)
                begin
                    cmd.op     = OP_REPLY;
                    state_next = ST_ACK;
                end
                else if (stat.out_free)
                begin
                    cmd.op     = OP_REPLY;
                    cmd.emit   = 1'b1;
                    cmd.rkind  = RK_UP;
                    state_next = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CHK1:
            begin
                if (stat.walk_end)
                begin
                    cmd.op     = OP_IDX_CLR;
                    state_next = ST_CHK2;
                end
                else if (!stat.chk1_hit || stat.out_free)
                begin
                    cmd.op    = OP_CHK1;
                    cmd.emit  = stat.chk1_hit;
                    cmd.rkind = RK_DOWN;
                    cmd.src   = SRC_ENTRY;
                end
            end
            ST_CHK2:
            begin
                if (stat.walk_end)
                begin
                    state_next = ST_DONE;
                end
                else if (!stat.chk2_hit || stat.out_free)
                begin
                    cmd.op    = OP_CHK2;
                    cmd.emit  = stat.chk2_hit;
                    cmd.rkind = RK_PING;
                    cmd.src   = SRC_ENTRY;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.rkind  = RK_DONE;
                    cmd.src    = SRC_ZERO;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/peer_liveness_table.sv -----
// Top level of the peer liveness table: stream ports, config port, controller and datapath.
// Throughput: one item at a time, as s_axis_tready is high only while idle; the walks over
// the table take one entry per cycle, except that a check walk stalls while a down or ping
// beat waits on m_axis_tready, and every result beat also waits on m_axis_tready.
// Reset: table empty, expire_age 10, valid_age 6, add_backdate 3, no result pending.
module peer_liveness_table
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,  // peer_addr[31:0], now_time[63:32]
    input  logic [plt_pkg::KIND_W-1:0]    s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [39:0]                   m_axis_tdata,  // event_addr, peer_up[32], ok[33]
    output logic [plt_pkg::KIND_W-1:0]    m_axis_tuser,  // result_kind
    output logic                          m_axis_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [plt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plt_pkg::AGE_W-1:0]     cfg_data
);
    import plt_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [ADDR_W-1:0] out_addr;
    logic              out_up;
    logic              out_ok;

    plt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plt_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_kind   (s_axis_tuser),
        .in_addr   (s_axis_tdata[31:0]),
        .in_now    (s_axis_tdata[63:32]),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_addr  (out_addr),
        .out_up    (out_up),
        .out_ok    (out_ok),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, out_ok, out_up, out_addr};

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the peer liveness table: stream stimulus, predictor, checker.
module tb;
    import plt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_BACKDATE + 1'b1;
    localparam logic [KIND_W-1:0] KIND_TOP = {KIND_W{1'b1}};
    localparam int POOL = 20;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now;
    } peer_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] rk;
        logic [ADDR_W-1:0] addr;
        logic              up;
        logic              ok;
        logic              last;
    } peer_evt_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [KIND_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [KIND_W-1:0] m_axis_tuser;
    logic m_axis_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [AGE_W-1:0] cfg_data = '0;

    peer_liveness_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // predicted table contents and registers
    logic [ADDR_W-1:0] mdl_addr [DEPTH];
    logic [TIME_W-1:0] mdl_seen [DEPTH];
    logic              mdl_alive [DEPTH];
    int                mdl_cnt = 0;
    logic [AGE_W-1:0]  mdl_expire = EXPIRE_RST;
    logic [AGE_W-1:0]  mdl_valid = VALID_RST;
    logic [AGE_W-1:0]  mdl_backdate = BACKDATE_RST;

    peer_cmd_t cmd_queue [$];
    peer_evt_t evt_expected [$];
    peer_cmd_t feed_cmd = '0;
    peer_evt_t head_evt;
    logic [ADDR_W-1:0] addr_pool [POOL];
    logic [TIME_W-1:0] wall_clock = '0;

    bit feed_busy = 1'b0;
    bit in_fire = 1'b0;
    bit idle_on = 1'b1;
    int feed_gap = 0;
    int drain_gap = 0;
    int mismatches = 0;
    int beats_in = 0;
    int beats_out = 0;
    int settings_used = 1;

    function automatic peer_evt_t mk_evt(input logic [KIND_W-1:0] rk, input logic [ADDR_W-1:0] a,
                                         input logic up, input logic ok);
        peer_evt_t e;
        e.rk = rk;
        e.addr = a;
        e.up = up;
        e.ok = ok;
        e.last = 1'b0;
        return e;
    endfunction

    function automatic void predict_peer_item(input peer_cmd_t c);
        peer_evt_t out_q [$];
        int i;
        int pos;
        int hit;
        logic good;
        logic [TIME_W-1:0] age;
        hit = -1;
        for (i = 0; i < mdl_cnt; i++)
            if (hit < 0 && mdl_addr[i] == c.addr)
                hit = i;
        case (c.kind)
            KIND_ADD:
            begin
                good = (hit < 0) && (mdl_cnt < DEPTH);
                if (good)
                begin
                    pos = 0;
                    while (pos < mdl_cnt && mdl_addr[pos] <= c.addr)
                        pos++;
                    for (i = mdl_cnt; i > pos; i--)
                    begin
                        mdl_addr[i] = mdl_addr[i-1];
                        mdl_seen[i] = mdl_seen[i-1];
                        mdl_alive[i] = mdl_alive[i-1];
                    end
                    mdl_addr[pos] = c.addr;
                    mdl_seen[pos] = c.now - {16'd0, mdl_backdate};
                    mdl_alive[pos] = 1'b1;
                    mdl_cnt++;
                end
                out_q.push_back(mk_evt(RK_ACK, c.addr, 1'b0, good));
            end
            KIND_DEL:
            begin
                if (hit >= 0)
                begin
                    for (i = hit; i < mdl_cnt - 1; i++)
                    begin
                        mdl_addr[i] = mdl_addr[i+1];
                        mdl_seen[i] = mdl_seen[i+1];
                        mdl_alive[i] = mdl_alive[i+1];
                    end
                    mdl_cnt--;
                end
                out_q.push_back(mk_evt(RK_ACK, c.addr, 1'b0, hit >= 0));
            end
            KIND_REPLY:
            begin
                if (hit >= 0)
                begin
                    mdl_seen[hit] = c.now;
                    if (!mdl_alive[hit])
                    begin
                        mdl_alive[hit] = 1'b1;
                        out_q.push_back(mk_evt(RK_UP, c.addr, 1'b0, 1'b0));
                    end
                end
                out_q.push_back(mk_evt(RK_ACK, c.addr, 1'b0, hit >= 0));
            end
            KIND_QUERY:
            begin
                out_q.push_back(mk_evt(RK_ACK, c.addr, (hit >= 0) ? mdl_alive[hit] : 1'b0,
                                       hit >= 0));
            end
            KIND_CHECK:
            begin
                for (i = 0; i < mdl_cnt; i++)
                begin
                    if (c.now < mdl_seen[i])
                        mdl_seen[i] = c.now;
                    age = c.now - mdl_seen[i];
                    if (age >= {16'd0, mdl_expire} && mdl_alive[i])
                    begin
                        mdl_alive[i] = 1'b0;
                        out_q.push_back(mk_evt(RK_DOWN, mdl_addr[i], 1'b0, 1'b0));
                    end
                end
                for (i = 0; i < mdl_cnt; i++)
                begin
                    age = c.now - mdl_seen[i];
                    if (age >= {16'd0, mdl_valid})
                    begin
                        if (age > {16'd0, mdl_expire})
                            mdl_seen[i] = c.now;
                        else
                            out_q.push_back(mk_evt(RK_PING, mdl_addr[i], 1'b0, 1'b0));
                    end
                end
                out_q.push_back(mk_evt(RK_DONE, '0, 1'b0, 1'b0));
            end
            default:
                out_q.push_back(mk_evt(RK_ACK, c.addr, 1'b0, 1'b0));
        endcase
        out_q[out_q.size()-1].last = 1'b1;
        foreach (out_q[i])
            evt_expected.push_back(out_q[i]);
    endfunction

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
            mismatches++;
        end
    endfunction

    // input beats: driven at falling edge, item changes only after acceptance
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                in_fire = 1'b0;
                feed_busy = 1'b0;
            end
            if (!feed_busy)
            begin
                if (feed_gap > 0)
                    feed_gap--;
                else if (cmd_queue.size() > 0)
                begin
                    if (idle_on && $urandom_range(0, 3) == 0)
                        feed_gap = $urandom_range(1, 11) - 1;
                    else
                    begin
                        feed_cmd = cmd_queue.pop_front();
                        feed_busy = 1'b1;
                    end
                end
            end
            s_axis_tvalid <= feed_busy;
            s_axis_tdata <= {feed_cmd.now, feed_cmd.addr};
            s_axis_tuser <= feed_cmd.kind;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_peer_item({s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]});
            in_fire = 1'b1;
            beats_in++;
        end
    end

    // result side backpressure
    always @(negedge clk)
    begin
        if (drain_gap > 0)
        begin
            drain_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (rst_n && idle_on && $urandom_range(0, 4) == 0)
        begin
            drain_gap = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_out++;
            if (evt_expected.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0d addr 0x%0h",
                       m_axis_tuser, m_axis_tdata[31:0]);
                mismatches++;
            end
            else
            begin
                head_evt = evt_expected.pop_front();
                check_field("result_kind", 32'(head_evt.rk), 32'(m_axis_tuser));
                check_field("event_addr", head_evt.addr, m_axis_tdata[31:0]);
                check_field("peer_up", 32'(head_evt.up), 32'(m_axis_tdata[32]));
                check_field("ok", 32'(head_evt.ok), 32'(m_axis_tdata[33]));
                check_field("last", 32'(head_evt.last), 32'(m_axis_tlast));
            end
        end
    end

    task automatic queue_cmd(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] a,
                             input logic [TIME_W-1:0] now);
        cmd_queue.push_back({kind, a, now});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [AGE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_EXPIRE:   mdl_expire = val;
            CFG_VALID:    mdl_valid = val;
            CFG_BACKDATE: mdl_backdate = val;
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (cmd_queue.size() != 0 || feed_busy || evt_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_ages(input logic [AGE_W-1:0] expire, input logic [AGE_W-1:0] valid,
                            input logic [AGE_W-1:0] backdate);
        write_reg(CFG_EXPIRE, expire);
        write_reg(CFG_VALID, valid);
        write_reg(CFG_BACKDATE, backdate);
        settings_used++;
    endtask

    // mostly a small address pool so the table fills up and peers get revisited
    task automatic queue_random(input int count, input int add_pct);
        peer_cmd_t c;
        int pick;
        int n;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < add_pct)
                c.kind = KIND_ADD;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    c.kind = KIND_DEL;
                else if (pick < 45)
                    c.kind = KIND_REPLY;
                else if (pick < 63)
                    c.kind = KIND_QUERY;
                else if (pick < 93)
                    c.kind = KIND_CHECK;
                else
                    c.kind = KIND_W'($urandom_range(int'(KIND_CHECK) + 1, int'(KIND_TOP)));
            end
            if ($urandom_range(0, 9) == 0)
                c.addr = $urandom();
            else
                c.addr = addr_pool[$urandom_range(0, POOL - 1)];
            if ($urandom_range(0, 19) == 0)
                wall_clock = $urandom();
            else
                wall_clock += $urandom_range(0, int'(mdl_expire) / 2 + 2);
            c.now = wall_clock;
            cmd_queue.push_back(c);
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int k;
        for (k = 0; k < POOL; k++)
            addr_pool[k] = $urandom();
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed pass at reset ages: empty table, unknown kinds, wrap, down/up/ping
        queue_cmd(KIND_CHECK, 32'h0000_1234, 32'd100);
        queue_cmd(KIND_QUERY, 32'h0000_1234, 32'd100);
        queue_cmd(KIND_DEL, 32'h0000_1234, 32'd100);
        queue_cmd(KIND_REPLY, 32'h0000_1234, 32'd100);
        queue_cmd(KIND_CHECK + 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(KIND_CHECK + 3'd2, 32'h5A5A_A5A5, 32'd0);
        queue_cmd(KIND_TOP, 32'h0000_0000, 32'd5);
        queue_cmd(KIND_ADD, 32'h0000_0000, 32'd1);
        queue_cmd(KIND_ADD, 32'hFFFF_FFFF, 32'd100);
        queue_cmd(KIND_ADD, 32'h0000_0000, 32'd100);
        queue_cmd(KIND_ADD, 32'h8000_0000, 32'd100);
        queue_cmd(KIND_QUERY, 32'h8000_0000, 32'd100);
        queue_cmd(KIND_CHECK, 32'h0000_0000, 32'd100);
        queue_cmd(KIND_CHECK, 32'h0000_0000, 32'd104);
        queue_cmd(KIND_CHECK, 32'h0000_0000, 32'd107);
        queue_cmd(KIND_QUERY, 32'hFFFF_FFFF, 32'd107);
        queue_cmd(KIND_REPLY, 32'hFFFF_FFFF, 32'd108);
        queue_cmd(KIND_CHECK, 32'h0000_0000, 32'd200);
        queue_cmd(KIND_REPLY, 32'h0000_0000, 32'd201);
        queue_cmd(KIND_DEL, 32'h8000_0000, 32'd201);
        queue_cmd(KIND_DEL, 32'h0000_0000, 32'd201);
        queue_cmd(KIND_QUERY, 32'h0000_0000, 32'd201);
        queue_cmd(KIND_ADD, 32'h0000_0001, 32'hFFFF_FFFF);
        queue_cmd(KIND_CHECK, 32'h0000_0000, 32'hFFFF_FFFF);
        settle();

        set_ages(16'd1, 16'd0, 16'd0);
        queue_random(51, 60);
        settle();

        set_ages(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_SPARE, 16'hA5A5);
        queue_random(51, 25);
        settle();

        idle_on = 1'b0;
        set_ages(16'd0, 16'd0, 16'd1);
        queue_random(51, 30);
        settle();

        idle_on = 1'b1;
        set_ages(16'd30, 16'd12, 16'd7);
        queue_random(51, 30);
        settle();

        idle_on = 1'b0;
        set_ages(EXPIRE_RST, VALID_RST, BACKDATE_RST);
        queue_random(51, 30);
        settle();

        $display("covered %0d input beats and %0d result beats over %0d age settings",
                 beats_in, beats_out, settings_used);
        $display("%0d peers left in the table, %0d field mismatches", mdl_cnt, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
